>>> src/wsfr_pkg.sv
`default_nettype none

package wsfr_pkg;

  // Queue between the byte classifier and the frame parser
  localparam int QUEUE_DEPTH_DEF = 4;

  // Frame identifier reset values
  localparam logic [7:0] STRING_ID_RST = 8'd129;
  localparam logic [7:0] BINARY_ID_RST = 8'd130;

  // Header fields of the second byte
  localparam logic [7:0] MASK_BIT  = 8'h80;
  localparam logic [7:0] LEN_BITS  = 8'h7F;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Result kinds
  localparam logic [1:0] KIND_BYTE        = 2'd0;
  localparam logic [1:0] KIND_EMPTY       = 2'd1;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_STRING_ID = 1'b0;
  localparam logic REG_BINARY_ID = 1'b1;

  typedef enum logic [1:0] {
    CLS_DATA   = 2'd0,
    CLS_TEXT   = 2'd1,
    CLS_BINARY = 2'd2,
    CLS_OTHER  = 2'd3
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [5:0] {
    PH_SKIP    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_EXT_HI  = 6'b000100,
    PH_EXT_LO  = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

endpackage

`default_nettype wire

>>> src/wsfr_if.sv
`default_nettype none

interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_start;

  modport source (output valid, output data_byte, output buffer_start, input ready);
  modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface wsfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic       frame_is_binary;
  logic       last_of_frame;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_is_binary, output last_of_frame, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_is_binary, input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> src/wsfr_front.sv
`default_nettype none

module wsfr_front (
  wsfr_in_if.sink              in_if,
  input  wire logic [7:0]      string_id,
  input  wire logic [7:0]      binary_id,
  input  wire wsfr_pkg::q_status_t q_status,
  output logic                 push,
  output wsfr_pkg::q_entry_t   push_entry
);

  assign in_if.ready = !q_status.full;
  assign push        = in_if.valid && !q_status.full;

  // Start bytes are matched against the ids here; text wins on a tie.
  always_comb begin
    push_entry.data = in_if.data_byte;
    if (!in_if.buffer_start) begin
      push_entry.cls = wsfr_pkg::CLS_DATA;
    end else if (in_if.data_byte == string_id) begin
      push_entry.cls = wsfr_pkg::CLS_TEXT;
    end else if (in_if.data_byte == binary_id) begin
      push_entry.cls = wsfr_pkg::CLS_BINARY;
    end else begin
      push_entry.cls = wsfr_pkg::CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

>>> src/wsfr_queue.sv
`default_nettype none

module wsfr_queue #(
  parameter int DEPTH = wsfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire wsfr_pkg::q_entry_t  push_entry,
  input  wire logic                pop,
  output wsfr_pkg::q_entry_t       pop_entry,
  output wsfr_pkg::q_status_t      status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsfr_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry    = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule

`default_nettype wire

>>> src/wsfr_back.sv
`default_nettype none

module wsfr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wsfr_pkg::q_status_t q_status,
  input  wire wsfr_pkg::q_entry_t  entry,
  output logic                     pop,
  wsfr_out_if.source               out_if
);

  wsfr_pkg::phase_t phase_r, phase_nxt;
  logic        binary_r, binary_nxt;
  logic        masked_r, masked_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  key_r [4];
  logic [1:0]  kpos_r, kpos_nxt;
  logic        key_we;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic        bin_out_r;
  logic        last_r;

  logic        emit;
  logic [1:0]  e_kind;
  logic [7:0]  e_byte;
  logic        e_last;
  logic        len_known;
  logic [15:0] len_val;
  logic        len_masked;
  logic [7:0]  key_byte;
  logic [15:0] rem_dec;

  assign pop      = !q_status.empty && (!out_valid_r || out_if.ready);
  assign key_byte = masked_r ? key_r[kpos_r] : 8'h00;
  assign rem_dec  = rem_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    binary_nxt = binary_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    kpos_nxt   = kpos_r;
    key_we     = 1'b0;
    emit       = 1'b0;
    e_kind     = wsfr_pkg::KIND_BYTE;
    e_byte     = 8'h00;
    e_last     = 1'b0;
    len_known  = 1'b0;
    len_val    = rem_r;
    len_masked = masked_r;

    if (pop) begin
      case (entry.cls)
        wsfr_pkg::CLS_TEXT: begin
          binary_nxt = 1'b0;
          phase_nxt  = wsfr_pkg::PH_LEN;
        end
        wsfr_pkg::CLS_BINARY: begin
          binary_nxt = 1'b1;
          phase_nxt  = wsfr_pkg::PH_LEN;
        end
        wsfr_pkg::CLS_OTHER: begin
          phase_nxt = wsfr_pkg::PH_SKIP;
        end
        default: begin
          case (phase_r)
            wsfr_pkg::PH_LEN: begin
              masked_nxt = |(entry.data & wsfr_pkg::MASK_BIT);
              len_masked = masked_nxt;
              if (entry.data[6:0] == wsfr_pkg::LEN_EXT16) begin
                phase_nxt = wsfr_pkg::PH_EXT_HI;
              end else if (entry.data[6:0] == wsfr_pkg::LEN_EXT64) begin
                phase_nxt = wsfr_pkg::PH_SKIP;
                emit      = 1'b1;
                e_kind    = wsfr_pkg::KIND_UNSUPPORTED;
                e_last    = 1'b1;
              end else begin
                len_val   = {8'h00, entry.data & wsfr_pkg::LEN_BITS};
                rem_nxt   = len_val;
                len_known = 1'b1;
              end
            end
            wsfr_pkg::PH_EXT_HI: begin
              rem_nxt   = {entry.data, 8'h00};
              phase_nxt = wsfr_pkg::PH_EXT_LO;
            end
            wsfr_pkg::PH_EXT_LO: begin
              len_val   = rem_r | {8'h00, entry.data};
              rem_nxt   = len_val;
              len_known = 1'b1;
            end
            wsfr_pkg::PH_KEY: begin
              key_we   = 1'b1;
              kpos_nxt = kpos_r + 2'd1;
              if (kpos_r == 2'd3) begin
                if (rem_r == 16'd0) begin
                  phase_nxt = wsfr_pkg::PH_SKIP;
                  emit      = 1'b1;
                  e_kind    = wsfr_pkg::KIND_EMPTY;
                  e_last    = 1'b1;
                end else begin
                  phase_nxt = wsfr_pkg::PH_PAYLOAD;
                end
              end
            end
            wsfr_pkg::PH_PAYLOAD: begin
              kpos_nxt = kpos_r + 2'd1;
              rem_nxt  = rem_dec;
              emit     = 1'b1;
              e_kind   = wsfr_pkg::KIND_BYTE;
              e_byte   = entry.data ^ key_byte;
              e_last   = (rem_dec == 16'd0);
              if (rem_dec == 16'd0) begin
                phase_nxt = wsfr_pkg::PH_SKIP;
              end
            end
            default: begin
              phase_nxt = wsfr_pkg::PH_SKIP;
            end
          endcase

          // length settled: key bytes, payload, or an empty frame
          if (len_known) begin
            kpos_nxt = 2'd0;
            if (len_masked) begin
              phase_nxt = wsfr_pkg::PH_KEY;
            end else if (len_val == 16'd0) begin
              phase_nxt = wsfr_pkg::PH_SKIP;
              emit      = 1'b1;
              e_kind    = wsfr_pkg::KIND_EMPTY;
              e_last    = 1'b1;
            end else begin
              phase_nxt = wsfr_pkg::PH_PAYLOAD;
            end
          end
        end
      endcase
    end

    if (out_valid_r && !out_if.ready) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wsfr_pkg::PH_SKIP;
      binary_r    <= 1'b0;
      masked_r    <= 1'b0;
      rem_r       <= 16'd0;
      kpos_r      <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= 8'h00;
      end
    end else begin
      phase_r     <= phase_nxt;
      binary_r    <= binary_nxt;
      masked_r    <= masked_nxt;
      rem_r       <= rem_nxt;
      kpos_r      <= kpos_nxt;
      out_valid_r <= out_valid_nxt;
      if (key_we) begin
        key_r[kpos_r] <= entry.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_r    <= e_kind;
      byte_r    <= e_byte;
      bin_out_r <= binary_r;
      last_r    <= e_last;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.result_kind     = kind_r;
  assign out_if.payload_byte    = byte_r;
  assign out_if.frame_is_binary = bin_out_r;
  assign out_if.last_of_frame   = last_r;

endmodule

`default_nettype wire

>>> src/websocket_frame_receiver.sv
// Channel   Dir   Word                                                    Handshake
// in_if     in    data_byte[7:0], buffer_start                           valid/ready
// out_if    out   result_kind[1:0], payload_byte[7:0], frame_is_binary,  valid/ready
//                 last_of_frame
// apb       in    psel/penable/pwrite/paddr[2:0]/pwdata, prdata out      pready tied high
//
// One input word per cycle while the word queue has room; an accepted word is written into
// the queue, then popped by the parser, which loads any result into the output register,
// the only stall point; the parser handles one queued word per cycle unless it is stalled.
// in_if.ready drops only while the word queue is full; a stalled output backs up the queue.
// rst_n is synchronous, active low; it clears parser state and queue pointers and restores
// the default ids.
`default_nettype none

module websocket_frame_receiver #(
  parameter int QUEUE_DEPTH = wsfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wsfr_in_if.sink          in_if,
  wsfr_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration: two 8-bit frame ids at byte offsets 0 and 4.
  logic [7:0] string_id_r;
  logic [7:0] binary_id_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      string_id_r <= wsfr_pkg::STRING_ID_RST;
      binary_id_r <= wsfr_pkg::BINARY_ID_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == wsfr_pkg::REG_STRING_ID) begin
        string_id_r <= pwdata[7:0];
      end else begin
        binary_id_r <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == wsfr_pkg::REG_BINARY_ID) ? {24'h0, binary_id_r}
                                                        : {24'h0, string_id_r};

  // Front: classify start bytes against the ids, push into the queue.
  logic                q_push;
  logic                q_pop;
  wsfr_pkg::q_entry_t  q_in;
  wsfr_pkg::q_entry_t  q_out;
  wsfr_pkg::q_status_t q_status;

  wsfr_front u_front (
    .in_if      (in_if),
    .string_id  (string_id_r),
    .binary_id  (binary_id_r),
    .q_status   (q_status),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Short word queue decouples input acceptance from parser stalls.
  wsfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .status     (q_status)
  );

  // Back: header parse, mask key capture, unmasking, registered result.
  wsfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .entry    (q_out),
    .pop      (q_pop),
    .out_if   (out_if)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("word popped from empty queue");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> q_status.full)
    else $error("input stalled with queue space left");

  a_nonbyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.result_kind != wsfr_pkg::KIND_BYTE) |-> out_if.last_of_frame)
    else $error("empty or unsupported result without last mark");
`endif

endmodule

`default_nettype wire
